// File: src/gipt_pkg.sv
// gipt_pkg: shared widths, register indexes, reset values and types of the pan/tilt tracker
// no dependencies; used by every module under src
package gipt_pkg;

	// field widths
	localparam int ERR_W  = 12;
	localparam int CFG_W  = 12;
	localparam int IDX_W  = 4;
	localparam int STEP_W = 9;
	localparam int PAN_W  = 13;
	localparam int TILT_W = 12;
	localparam int SUM_W  = 14;

	// serial divider: quotient bits resolved one per cycle, product width
	localparam int DIV_BITS = 9;
	localparam int PROD_W   = 20;
	localparam int CNT_W    = 4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_DEAD_ZONE   = 4'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_NUM    = 4'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DEN    = 4'd2;
	localparam logic [IDX_W-1:0] REG_STEP_LIMIT  = 4'd3;
	localparam logic [IDX_W-1:0] REG_PAN_LIMIT   = 4'd4;
	localparam logic [IDX_W-1:0] REG_TILT_MIN    = 4'd5;
	localparam logic [IDX_W-1:0] REG_TILT_MAX    = 4'd6;
	localparam logic [IDX_W-1:0] REG_AXIS_INVERT = 4'd7;

	// register reset values
	localparam logic [7:0]  RST_DEAD_ZONE   = 8'd5;
	localparam logic [7:0]  RST_GAIN_NUM    = 8'd1;
	localparam logic [7:0]  RST_GAIN_DEN    = 8'd1;
	localparam logic [7:0]  RST_STEP_LIMIT  = 8'd20;
	localparam logic [11:0] RST_PAN_LIMIT   = 12'd900;
	localparam logic [11:0] RST_TILT_MIN    = 12'd115;
	localparam logic [11:0] RST_TILT_MAX    = 12'd2785;
	localparam logic [1:0]  RST_AXIS_INVERT = 2'd0;

	// position reset values
	localparam logic [PAN_W-1:0]  RST_PAN_POS  = 13'd0;
	localparam logic [TILT_W-1:0] RST_TILT_POS = 12'd1450;

	// configuration register bank
	typedef struct packed {
		logic [7:0]  dead_zone;
		logic [7:0]  gain_num;
		logic [7:0]  gain_den;
		logic [7:0]  step_limit;
		logic [11:0] pan_limit;
		logic [11:0] tilt_min;
		logic [11:0] tilt_max;
		logic [1:0]  axis_invert;
	} cfg_t;

	// sequencer strobes to the axis datapaths
	typedef struct packed {
		logic load;
		logic mul;
		logic div;
		logic fin;
	} ax_ctrl_t;

endpackage

// File: src/gipt_cfg.sv
// gipt_cfg: configuration register bank of the tracker
// depends on gipt_pkg
module gipt_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [gipt_pkg::IDX_W-1:0] cfg_index,
	input  logic [gipt_pkg::CFG_W-1:0] cfg_data,
	output gipt_pkg::cfg_t             cfg
);

	gipt_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone   <= gipt_pkg::RST_DEAD_ZONE;
			cfg_q.gain_num    <= gipt_pkg::RST_GAIN_NUM;
			cfg_q.gain_den    <= gipt_pkg::RST_GAIN_DEN;
			cfg_q.step_limit  <= gipt_pkg::RST_STEP_LIMIT;
			cfg_q.pan_limit   <= gipt_pkg::RST_PAN_LIMIT;
			cfg_q.tilt_min    <= gipt_pkg::RST_TILT_MIN;
			cfg_q.tilt_max    <= gipt_pkg::RST_TILT_MAX;
			cfg_q.axis_invert <= gipt_pkg::RST_AXIS_INVERT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gipt_pkg::REG_DEAD_ZONE:   cfg_q.dead_zone   <= cfg_data[7:0];
				gipt_pkg::REG_GAIN_NUM:    cfg_q.gain_num    <= cfg_data[7:0];
				gipt_pkg::REG_GAIN_DEN:    cfg_q.gain_den    <= cfg_data[7:0];
				gipt_pkg::REG_STEP_LIMIT:  cfg_q.step_limit  <= cfg_data[7:0];
				gipt_pkg::REG_PAN_LIMIT:   cfg_q.pan_limit   <= cfg_data;
				gipt_pkg::REG_TILT_MIN:    cfg_q.tilt_min    <= cfg_data;
				gipt_pkg::REG_TILT_MAX:    cfg_q.tilt_max    <= cfg_data;
				gipt_pkg::REG_AXIS_INVERT: cfg_q.axis_invert <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: src/gipt_axis.sv
// gipt_axis: one axis of the tracker: dead zone, gain multiply, bit-serial divide, step clamp
// depends on gipt_pkg; sequenced by the top level through ax_ctrl_t
module gipt_axis (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gipt_pkg::ax_ctrl_t                 ctrl,
	input  logic signed [gipt_pkg::ERR_W-1:0]  err,
	input  logic                               invert,
	input  gipt_pkg::cfg_t                     cfg,
	output logic signed [gipt_pkg::STEP_W-1:0] step
);

	logic [gipt_pkg::ERR_W-1:0]    abs_err;
	logic [gipt_pkg::ERR_W-1:0]    mag_q;
	logic                          neg_q;
	logic [7:0]                    den_q;
	logic [gipt_pkg::PROD_W-1:0]   prod;
	logic                          ovf_q;
	logic [7:0]                    rem_q;
	logic [gipt_pkg::DIV_BITS-1:0] dig_q;
	logic [gipt_pkg::DIV_BITS-1:0] quo_q;
	logic [8:0]                    trial;
	logic                          qbit;
	logic [gipt_pkg::STEP_W-1:0]   clip_mag;
	logic signed [gipt_pkg::STEP_W-1:0] step_q;

	// magnitude of the error before the dead zone
	assign abs_err = err[gipt_pkg::ERR_W-1] ? (~err + 12'd1) : err;

	// frame capture: dead zone, direction, denominator of zero read as one
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= (abs_err < {4'd0, cfg.dead_zone}) ? '0 : abs_err;
			neg_q <= err[gipt_pkg::ERR_W-1] ^ invert;
			den_q <= (cfg.gain_den == 8'd0) ? 8'd1 : cfg.gain_den;
		end
	end

	// gain product, upper part seeds the remainder
	assign prod = gipt_pkg::PROD_W'(mag_q) * gipt_pkg::PROD_W'(cfg.gain_num);

	// restoring divide step on the next dividend bit
	assign trial = {rem_q, dig_q[gipt_pkg::DIV_BITS-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	// dividend shift register, remainder and quotient
	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			ovf_q <= (prod[gipt_pkg::PROD_W-1:gipt_pkg::DIV_BITS] >= {3'd0, den_q});
			rem_q <= prod[gipt_pkg::DIV_BITS+7:gipt_pkg::DIV_BITS];
			dig_q <= prod[gipt_pkg::DIV_BITS-1:0];
			quo_q <= '0;
		end else if (ctrl.div) begin
			rem_q <= qbit ? 8'(trial - {1'b0, den_q}) : trial[7:0];
			dig_q <= {dig_q[gipt_pkg::DIV_BITS-2:0], 1'b0};
			quo_q <= {quo_q[gipt_pkg::DIV_BITS-2:0], qbit};
		end
	end

	// quotient of 512 or more always exceeds the step limit
	assign clip_mag = (ovf_q || (quo_q > {1'b0, cfg.step_limit})) ?
		{1'b0, cfg.step_limit} : quo_q;

	// signed, clamped step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctrl.fin) begin
			step_q <= neg_q ? -$signed(clip_mag) : $signed(clip_mag);
		end
	end

	assign step = step_q;

endmodule

// File: src/gimbal_incremental_p_tracker.sv
// gimbal_incremental_p_tracker: two-axis pan/tilt tracker top level
// depends on gipt_pkg, gipt_cfg, gipt_axis
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  in      | in_valid / in_ready     | error_x, error_y
//  out     | out_valid / out_ready   | pan_target, tilt_target, pan_step, tilt_step
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// each word passes through one capture, one gain multiply, the bit-serial divider
// (one quotient bit a cycle), one step clamp and one position update before the next
// word is accepted; both axes run side by side
// a finished result waits in the output register while the next word is worked on;
// the update stalls only while that register is still full
// reset restores the register defaults, pan 0 and tilt 1450; configuration is always ready
module gimbal_incremental_p_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [gipt_pkg::ERR_W-1:0]   error_x,
	input  logic signed [gipt_pkg::ERR_W-1:0]   error_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gipt_pkg::PAN_W-1:0]   pan_target,
	output logic [gipt_pkg::TILT_W-1:0]         tilt_target,
	output logic signed [gipt_pkg::STEP_W-1:0]  pan_step,
	output logic signed [gipt_pkg::STEP_W-1:0]  tilt_step,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gipt_pkg::IDX_W-1:0]          cfg_index,
	input  logic [gipt_pkg::CFG_W-1:0]          cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;

	localparam logic [gipt_pkg::CNT_W-1:0] DIV_LAST = gipt_pkg::CNT_W'(gipt_pkg::DIV_BITS - 1);

	gipt_pkg::cfg_t     cfg;
	gipt_pkg::ax_ctrl_t ctrl;

	logic [2:0]                  state_q;
	logic [gipt_pkg::CNT_W-1:0]  cnt_q;
	logic                        in_fire;
	logic                        upd_fire;
	logic                        out_valid_q;

	logic signed [gipt_pkg::STEP_W-1:0] dx;
	logic signed [gipt_pkg::STEP_W-1:0] dy;
	logic signed [gipt_pkg::STEP_W-1:0] pan_step_q;
	logic signed [gipt_pkg::STEP_W-1:0] tilt_step_q;
	logic signed [gipt_pkg::PAN_W-1:0]  pan_q;
	logic [gipt_pkg::TILT_W-1:0]        tilt_q;

	logic signed [gipt_pkg::SUM_W-1:0] pan_sum;
	logic signed [gipt_pkg::SUM_W-1:0] pan_hi;
	logic signed [gipt_pkg::SUM_W-1:0] pan_lo;
	logic signed [gipt_pkg::SUM_W-1:0] pan_c1;
	logic signed [gipt_pkg::SUM_W-1:0] pan_c2;
	logic signed [gipt_pkg::SUM_W-1:0] tilt_sum;
	logic signed [gipt_pkg::SUM_W-1:0] tilt_hi;
	logic signed [gipt_pkg::SUM_W-1:0] tilt_lo;
	logic signed [gipt_pkg::SUM_W-1:0] tilt_c1;
	logic signed [gipt_pkg::SUM_W-1:0] tilt_c2;

	// register bank
	gipt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshakes
	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign upd_fire = (state_q == S_UPD) && (!out_valid_q || out_ready);

	// strobes to both axes
	always_comb begin
		ctrl.load = in_fire;
		ctrl.mul  = (state_q == S_MUL);
		ctrl.div  = (state_q == S_DIV);
		ctrl.fin  = (state_q == S_FIN);
	end

	// pan and tilt datapaths
	gipt_axis u_pan (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.err    (error_x),
		.invert (cfg.axis_invert[0]),
		.cfg    (cfg),
		.step   (dx)
	);

	gipt_axis u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.err    (error_y),
		.invert (cfg.axis_invert[1]),
		.cfg    (cfg),
		.step   (dy)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_fire) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// pan: add step, clamp high then low
	assign pan_sum = {{(gipt_pkg::SUM_W-gipt_pkg::PAN_W){pan_q[gipt_pkg::PAN_W-1]}}, pan_q} +
		{{(gipt_pkg::SUM_W-gipt_pkg::STEP_W){dx[8]}}, dx};
	assign pan_hi  = $signed({2'b00, cfg.pan_limit});
	assign pan_lo  = -pan_hi;
	assign pan_c1  = (pan_sum > pan_hi) ? pan_hi : pan_sum;
	assign pan_c2  = (pan_c1 < pan_lo) ? pan_lo : pan_c1;

	// tilt: add step, clamp to max then min
	assign tilt_sum = $signed({2'b00, tilt_q}) +
		{{(gipt_pkg::SUM_W-gipt_pkg::STEP_W){dy[8]}}, dy};
	assign tilt_hi  = $signed({2'b00, cfg.tilt_max});
	assign tilt_lo  = $signed({2'b00, cfg.tilt_min});
	assign tilt_c1  = (tilt_sum > tilt_hi) ? tilt_hi : tilt_sum;
	assign tilt_c2  = (tilt_c1 < tilt_lo) ? tilt_lo : tilt_c1;

	// stored targets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_q  <= gipt_pkg::RST_PAN_POS;
			tilt_q <= gipt_pkg::RST_TILT_POS;
		end else if (upd_fire) begin
			pan_q  <= pan_c2[gipt_pkg::PAN_W-1:0];
			tilt_q <= tilt_c2[gipt_pkg::TILT_W-1:0];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			pan_step_q  <= dx;
			tilt_step_q <= dy;
		end
	end

	assign out_valid   = out_valid_q;
	assign pan_target  = pan_q;
	assign tilt_target = tilt_q;
	assign pan_step    = pan_step_q;
	assign tilt_step   = tilt_step_q;

`ifndef SYNTHESIS
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q <= DIV_LAST)
		else $error("divider count ran past the last quotient bit");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_MUL)
		else $error("accepted word did not start the multiply");

	a_update_shows: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire |=> out_valid_q)
		else $error("position update did not present a result");

	a_update_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && out_valid_q && !out_ready) |=> state_q == S_UPD)
		else $error("update left while the output word was still held");
`endif

endmodule

// File: test/tb_gimbal_incremental_p_tracker.sv
// tb_gimbal_incremental_p_tracker: self-checking bench for the pan/tilt tracker
// needs gipt_pkg and gimbal_incremental_p_tracker; a table of directed frames and writes,
// then randomised register settings and frames under four idling patterns
`timescale 1ns / 1ps

module tb_gimbal_incremental_p_tracker;
	import gipt_pkg::*;

	localparam int RESET_CYCLES       = 9;
	localparam int DRAIN_CYCLES       = 16;
	localparam int CYCLE_LIMIT        = 600000;
	localparam int SEGMENTS           = 8;
	localparam int FRAMES_PER_SEGMENT = 188;

	// indexes with no register behind them
	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
	localparam logic [IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

	typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;
	typedef enum int {BIAS_MIXED, BIAS_LOW, BIAS_HIGH} setting_bias_t;

	typedef struct packed {
		logic signed [PAN_W-1:0]  pan;
		logic [TILT_W-1:0]        tilt;
		logic signed [STEP_W-1:0] pan_step;
		logic signed [STEP_W-1:0] tilt_step;
	} gimbal_targets_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [IDX_W-1:0]         index;
		logic [CFG_W-1:0]         data;
		logic signed [ERR_W-1:0]  ex;
		logic signed [ERR_W-1:0]  ey;
		logic                     typed;
		gimbal_targets_t          want;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic signed [ERR_W-1:0]    error_x = '0;
	logic signed [ERR_W-1:0]    error_y = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [PAN_W-1:0]    pan_target;
	logic [TILT_W-1:0]          tilt_target;
	logic signed [STEP_W-1:0]   pan_step;
	logic signed [STEP_W-1:0]   tilt_step;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [IDX_W-1:0]           cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	// predictor state: register shadow and stored targets
	cfg_t                       shadow;
	int                         pan_pos;
	int                         tilt_pos;
	gimbal_targets_t            targets_due[$];

	int                         send_idle_pct = 0;
	int                         recv_stall_pct = 0;
	int                         failures = 0;
	int                         frames_sent = 0;
	int                         results_seen = 0;
	int                         writes_done = 0;
	int                         cycle_count = 0;
	stim_row_t                  plan[$];

	gimbal_incremental_p_tracker DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.error_x     (error_x),
		.error_y     (error_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pan_target  (pan_target),
		.tilt_target (tilt_target),
		.pan_step    (pan_step),
		.tilt_step   (tilt_step),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #2 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d words still due", $time, targets_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// one axis: dead zone, direction, gain with truncating divide, step clamp
	function automatic logic signed [STEP_W-1:0] axis_correction(int err, logic invert);
		int dz;
		int den;
		int lim;
		int d;
		dz  = shadow.dead_zone;
		den = (shadow.gain_den == 8'd0) ? 1 : int'(shadow.gain_den);
		lim = shadow.step_limit;
		if (err > -dz && err < dz)
			err = 0;
		if (invert)
			err = -err;
		d = int'(shadow.gain_num) * err / den;
		if (d > lim)
			d = lim;
		if (d < -lim)
			d = -lim;
		return STEP_W'(d);
	endfunction

	// advance both stored targets by one frame and return the word the block should send
	function automatic gimbal_targets_t advance_targets(logic signed [ERR_W-1:0] ex,
			logic signed [ERR_W-1:0] ey);
		gimbal_targets_t r;
		int dx;
		int dy;
		int pl;
		dx = axis_correction(ex, shadow.axis_invert[0]);
		dy = axis_correction(ey, shadow.axis_invert[1]);
		pl = shadow.pan_limit;
		pan_pos = pan_pos + dx;
		if (pan_pos > pl)
			pan_pos = pl;
		if (pan_pos < -pl)
			pan_pos = -pl;
		// upper bound first, so crossed bounds settle on the minimum
		tilt_pos = tilt_pos + dy;
		if (tilt_pos > int'(shadow.tilt_max))
			tilt_pos = shadow.tilt_max;
		if (tilt_pos < int'(shadow.tilt_min))
			tilt_pos = shadow.tilt_min;
		r.pan       = PAN_W'(pan_pos);
		r.tilt      = TILT_W'(tilt_pos);
		r.pan_step  = STEP_W'(dx);
		r.tilt_step = STEP_W'(dy);
		return r;
	endfunction

	// table row builders
	function automatic stim_row_t frame_row(int ex, int ey);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_FRAME;
		r.ex   = ERR_W'(ex);
		r.ey   = ERR_W'(ey);
		return r;
	endfunction

	function automatic stim_row_t checked_row(int ex, int ey, int pan, int tilt, int ps, int ts);
		stim_row_t r;
		r       = frame_row(ex, ey);
		r.typed = 1'b1;
		r.want  = '{PAN_W'(pan), TILT_W'(tilt), STEP_W'(ps), STEP_W'(ts)};
		return r;
	endfunction

	function automatic stim_row_t write_row(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_WRITE;
		r.index = index;
		r.data  = data;
		return r;
	endfunction

	// random register value: usual range with extremes now and then, or only the low or high extreme
	function automatic logic [CFG_W-1:0] pick_setting(int top, int usual, setting_bias_t bias);
		int roll;
		roll = $urandom_range(7);
		if (bias == BIAS_LOW || (bias == BIAS_MIXED && roll == 0))
			return '0;
		if (bias == BIAS_HIGH || (bias == BIAS_MIXED && roll == 1))
			return CFG_W'(top);
		return CFG_W'($urandom_range(usual));
	endfunction

	// random pixel error: extremes, around the dead zone, small, or anywhere
	function automatic logic signed [ERR_W-1:0] pick_error();
		int roll;
		int v;
		roll = $urandom_range(7);
		case (roll)
			0: v = -2048;
			1: v = 2047;
			2, 3: v = $urandom_range(60) - 30;
			4: v = $urandom_range(600) - 300;
			default: v = $urandom_range(4095) - 2048;
		endcase
		return ERR_W'(v);
	endfunction

	// register write word; the shadow follows on acceptance
	task automatic write_register(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_DEAD_ZONE:   shadow.dead_zone   = data[7:0];
			REG_GAIN_NUM:    shadow.gain_num    = data[7:0];
			REG_GAIN_DEN:    shadow.gain_den    = data[7:0];
			REG_STEP_LIMIT:  shadow.step_limit  = data[7:0];
			REG_PAN_LIMIT:   shadow.pan_limit   = data[11:0];
			REG_TILT_MIN:    shadow.tilt_min    = data[11:0];
			REG_TILT_MAX:    shadow.tilt_max    = data[11:0];
			REG_AXIS_INVERT: shadow.axis_invert = data[1:0];
			default: ;
		endcase
		writes_done++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one frame word, with a random gap ahead of it
	task automatic send_frame(input logic signed [ERR_W-1:0] ex, input logic signed [ERR_W-1:0] ey,
			input logic typed, input gimbal_targets_t typed_want);
		gimbal_targets_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		error_x  <= ex;
		error_y  <= ey;
		do @(posedge clk); while (!in_ready);
		predicted = advance_targets(ex, ey);
		targets_due.push_back(typed ? typed_want : predicted);
		frames_sent++;
	endtask

	// stop sending and let every due word come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (targets_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write every register, stray bits above each 8-bit or 2-bit field included, and one spare index
	task automatic configure_segment(input setting_bias_t bias);
		write_register(REG_DEAD_ZONE,   pick_setting(255, 30, bias) | (CFG_W'($urandom) << 8));
		write_register(REG_GAIN_NUM,    pick_setting(255, 255, bias) | (CFG_W'($urandom) << 8));
		write_register(REG_GAIN_DEN,    pick_setting(255, 16, bias) | (CFG_W'($urandom) << 8));
		write_register(REG_STEP_LIMIT,  pick_setting(255, 255, bias) | (CFG_W'($urandom) << 8));
		write_register(REG_PAN_LIMIT,   pick_setting(4095, 4095, bias));
		write_register(REG_TILT_MIN,    pick_setting(4095, 2000, bias));
		write_register(REG_TILT_MAX,    pick_setting(4095, 4095, bias));
		write_register(REG_AXIS_INVERT, pick_setting(3, 3, bias) | (CFG_W'($urandom) << 2));
		write_register(REG_SPARE_FIRST + IDX_W'($urandom_range(7)), CFG_W'($urandom));
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			failures++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		gimbal_targets_t want;
		if (arst_n && out_valid && out_ready) begin
			if (targets_due.size() == 0) begin
				$display("%0t: result word with none due, expected nothing, got pan %0d tilt %0d",
					$time, pan_target, tilt_target);
				failures++;
			end else begin
				want = targets_due.pop_front();
				check_field("pan_target", want.pan, pan_target);
				check_field("tilt_target", want.tilt, tilt_target);
				check_field("pan_step", want.pan_step, pan_step);
				check_field("tilt_step", want.tilt_step, tilt_step);
			end
			results_seen++;
		end
	end

	initial begin
		bit prev_frame;
		shadow = '{RST_DEAD_ZONE, RST_GAIN_NUM, RST_GAIN_DEN, RST_STEP_LIMIT,
			RST_PAN_LIMIT, RST_TILT_MIN, RST_TILT_MAX, RST_AXIS_INVERT};
		pan_pos  = $signed(RST_PAN_POS);
		tilt_pos = RST_TILT_POS;

		plan = '{
			// reset values, full-scale errors, dead zone edges
			checked_row(0, 0, 0, 1450, 0, 0),
			checked_row(2047, 2047, 20, 1470, 20, 20),
			checked_row(-2048, -2048, 0, 1450, -20, -20),
			checked_row(4, -4, 0, 1450, 0, 0),
			checked_row(5, -5, 5, 1445, 5, -5),
			checked_row(-1, 1, 5, 1445, 0, 0),
			// no dead zone, zero denominator, full gain
			write_row(REG_DEAD_ZONE, 0),
			write_row(REG_GAIN_DEN, 0),
			write_row(REG_GAIN_NUM, 255),
			write_row(REG_STEP_LIMIT, 255),
			frame_row(1, -1),
			frame_row(2047, 0),
			frame_row(-2048, 2047),
			// both axes inverted, widest limits
			write_row(REG_AXIS_INVERT, 3),
			write_row(REG_PAN_LIMIT, 4095),
			write_row(REG_TILT_MIN, 0),
			write_row(REG_TILT_MAX, 4095),
			frame_row(2047, -2048),
			frame_row(2047, -2048),
			frame_row(-300, 300),
			frame_row(-2048, 2047),
			// tilt bounds crossed
			write_row(REG_TILT_MIN, 3000),
			write_row(REG_TILT_MAX, 100),
			frame_row(0, 0),
			frame_row(-2048, -2048),
			// limits shrunk under the stored targets, no step allowed
			write_row(REG_PAN_LIMIT, 0),
			write_row(REG_TILT_MIN, 4095),
			write_row(REG_TILT_MAX, 4095),
			write_row(REG_STEP_LIMIT, 0),
			checked_row(100, -100, 0, 4095, 0, 0),
			// writes to spare indexes change nothing
			write_row(REG_SPARE_FIRST, 12'hFFF),
			write_row(REG_SPARE_LAST, 12'h5A5),
			checked_row(2047, 2047, 0, 4095, 0, 0),
			// stray upper bits, odd gain, widest dead zone
			write_row(REG_STEP_LIMIT, 12'hF7F),
			write_row(REG_PAN_LIMIT, 4095),
			write_row(REG_TILT_MIN, 0),
			write_row(REG_TILT_MAX, 4095),
			write_row(REG_AXIS_INVERT, 12'hFFC),
			write_row(REG_GAIN_NUM, 3),
			write_row(REG_GAIN_DEN, 7),
			write_row(REG_DEAD_ZONE, 255),
			frame_row(254, -254),
			frame_row(255, -255),
			frame_row(-255, 255),
			frame_row(-2048, 2047),
			frame_row(2047, -7)
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		prev_frame = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				if (prev_frame)
					settle();
				write_register(plan[i].index, plan[i].data);
				prev_frame = 1'b0;
			end else begin
				send_frame(plan[i].ex, plan[i].ey, plan[i].typed, plan[i].want);
				prev_frame = 1'b1;
			end
		end

		// random segments: new settings, then frames under one idling pattern
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			configure_segment(seg == 1 ? BIAS_LOW : (seg == 6 ? BIAS_HIGH : BIAS_MIXED));
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			repeat (FRAMES_PER_SEGMENT)
				send_frame(pick_error(), pick_error(), 1'b0, '0);
		end
		settle();

		$display("%0d frames sent and %0d result words checked", frames_sent, results_seen);
		$display("%0d register writes over %0d random settings and four idling patterns",
			writes_done, SEGMENTS);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
